// ----- rtl/core/bcwp_pkg.sv -----
package bcwp_pkg;

  // field widths
  localparam int PERIOD_W = 16;
  localparam int CMP_W    = 10;
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 16;
  localparam int RATE_W   = 7;
  localparam int LEVEL_W  = 10;

  // one state word per waveform: {upper field, rate} or {dc level}
  localparam int ENT_W    = IDX_W + RATE_W;
  localparam int WAVE_CNT = 3;
  localparam int ENT_AW   = $clog2(WAVE_CNT);

  // waveform codes
  localparam logic [MODE_W-1:0] WAVE_DC   = 2'd0;
  localparam logic [MODE_W-1:0] WAVE_SINE = 2'd1;
  localparam logic [MODE_W-1:0] WAVE_SAW  = 2'd2;
  localparam logic [MODE_W-1:0] WAVE_NONE = 2'd3;

  // register reset and key step limits
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;
  localparam logic [LEVEL_W-1:0]  DC_STEP       = 10'd10;
  localparam logic [LEVEL_W-1:0]  DC_MAX        = 10'd1000;
  localparam logic [RATE_W-1:0]   SINE_RATE_MIN = 7'd1;
  localparam logic [RATE_W-1:0]   SINE_RATE_MAX = 7'd100;
  localparam logic [RATE_W-1:0]   RAMP_RATE_MIN = 7'd8;
  localparam logic [RATE_W-1:0]   RAMP_RATE_MAX = 7'd96;
  localparam logic [RATE_W-1:0]   RAMP_RATE_STEP = 7'd8;
  localparam logic [LEVEL_W-1:0]  RAMP_TOP      = 10'd1000;

  // request and response of the sine unit
  typedef struct packed {
    logic              start;
    logic [IDX_W-1:0]  idx;
    logic [RATE_W-1:0] rate;
  } sine_req_t;

  typedef struct packed {
    logic             done;
    logic [CMP_W-1:0] sample;
  } sine_res_t;

  // state word value of a waveform entry that was never written
  function automatic logic [ENT_W-1:0] entry_reset(input logic [MODE_W-1:0] kind);
    logic [ENT_W-1:0] ent;
    ent = '0;
    case (kind)
      WAVE_SINE: ent = {{IDX_W{1'b0}}, SINE_RATE_MIN};
      WAVE_SAW:  ent = {{IDX_W{1'b0}}, RAMP_RATE_MIN};
      default:   ent = '0;
    endcase
    return ent;
  endfunction

endpackage

// ----- rtl/core/bcwp_if.sv -----
interface bcwp_in_if;
  logic valid;
  logic ready;
  logic action;
  logic key1_down;
  logic key2_down;

  modport source(output valid, action, key1_down, key2_down, input ready);
  modport sink(input valid, action, key1_down, key2_down, output ready);
endinterface

interface bcwp_out_if;
  import bcwp_pkg::*;
  logic             valid;
  logic             ready;
  logic             compare_write;
  logic [CMP_W-1:0] compare_value;
  logic [MODE_W-1:0] wave_mode;
  logic             in_select;

  modport source(output valid, compare_write, compare_value, wave_mode, in_select,
                 input ready);
  modport sink(input valid, compare_write, compare_value, wave_mode, in_select,
               output ready);
endinterface

// ----- rtl/core/bcwp_ram.sv -----
module bcwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bcwp_sine.sv -----
module bcwp_sine (
  input  logic                clk,
  input  logic                rst_n,
  input  bcwp_pkg::sine_req_t req,
  output bcwp_pkg::sine_res_t res
);
  import bcwp_pkg::*;

  localparam int          MOD_N      = 8000;
  localparam logic [31:0] RECIP_8000 = 32'd8589935;
  localparam logic [31:0] THETA_INT  = 32'd843314;
  localparam logic [31:0] THETA_FRAC = 32'd3426;
  localparam logic [31:0] RECIP_125  = 32'd268436;
  localparam logic [31:0] ONE        = 32'h4000_0000;
  localparam logic [31:0] SCALE      = 32'd499;
  localparam logic [10:0] SAMPLE_MAX = 11'd998;
  localparam logic [2:0]  LAST_TERM  = 3'd4;

  typedef enum logic [4:0] {
    SN_IDLE, SN_MOD_A, SN_MOD_B, SN_FOLD,
    SN_TH_A, SN_TH_B, SN_TH_C, SN_TH_D,
    SN_SQ_A, SN_SQ_B, SN_DIV_A, SN_DIV_B,
    SN_MT_A, SN_MT_B, SN_FIN_A, SN_FIN_B, SN_FIN_C, SN_FIN_D
  } sn_state_t;

  // taylor divisors, innermost first
  function automatic logic [6:0] div_const(input logic [2:0] k);
    logic [6:0] d;
    d = 7'd6;
    case (k)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^33 / divisor)
  function automatic logic [31:0] div_recip(input logic [2:0] k);
    logic [31:0] m;
    m = 32'd1431655765;
    case (k)
      3'd0:    m = 32'd78090314;
      3'd1:    m = 32'd119304647;
      3'd2:    m = 32'd204522252;
      3'd3:    m = 32'd429496729;
      default: m = 32'd1431655765;
    endcase
    return m;
  endfunction

  sn_state_t   state_r, state_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] mul_a, mul_b;
  logic [22:0] v_r, v_nxt;
  logic [12:0] p_r, p_nxt;
  logic [10:0] x_r, x_nxt;
  logic        neg_r, neg_nxt;
  logic [30:0] theta_r, theta_nxt;
  logic [31:0] t2_r, t2_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [30:0] a_r, a_nxt;
  logic [31:0] bias_r, bias_nxt;
  logic [2:0]  k_r, k_nxt;
  sine_res_t   res_r, res_nxt;

  // modulo 8000 correction
  logic [9:0]  q_mod;
  logic [22:0] qk;
  logic [13:0] p_w;
  logic [12:0] p_fix;
  assign q_mod = prod_r[45:36];
  assign qk    = 23'(q_mod) * 23'(MOD_N);
  assign p_w   = 14'(v_r - qk);
  assign p_fix = (p_w >= 14'(MOD_N)) ? 13'(p_w - 14'(MOD_N)) : p_w[12:0];

  // quarter wave fold
  logic [10:0] x_f;
  logic        neg_f;
  always_comb begin
    if (p_r < 13'd2000) begin
      x_f   = p_r[10:0];
      neg_f = 1'b0;
    end else if (p_r < 13'd4000) begin
      x_f   = 11'(13'd4000 - p_r);
      neg_f = 1'b0;
    end else if (p_r < 13'd6000) begin
      x_f   = 11'(p_r - 13'd4000);
      neg_f = 1'b1;
    end else begin
      x_f   = 11'(13'(MOD_N) - p_r);
      neg_f = 1'b1;
    end
  end

  // constant divide: reciprocal estimate, then one correction
  logic [30:0] q0;
  logic [6:0]  dconst;
  logic [37:0] qd;
  logic [32:0] rem;
  logic [30:0] quo;
  assign q0     = prod_r[63:33];
  assign dconst = div_const(k_r);
  assign qd     = 38'(q0) * 38'(dconst);
  assign rem    = {1'b0, dv_r} - qd[32:0];
  assign quo    = q0 + 31'(rem >= 33'(dconst));

  // final scaling
  logic [31:0] s_raw, s_cl;
  logic [10:0] smp;
  assign s_raw = prod_r[61:30];
  assign s_cl  = (s_raw > ONE) ? ONE : s_raw;
  assign smp   = prod_r[40:30];

  // sequencer around one shared multiplier
  always_comb begin
    state_nxt  = state_r;
    v_nxt      = v_r;
    p_nxt      = p_r;
    x_nxt      = x_r;
    neg_nxt    = neg_r;
    theta_nxt  = theta_r;
    t2_nxt     = t2_r;
    dv_nxt     = dv_r;
    a_nxt      = a_r;
    bias_nxt   = bias_r;
    k_nxt      = k_r;
    res_nxt    = res_r;
    res_nxt.done = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      SN_IDLE: begin
        mul_a = 32'(req.idx);
        mul_b = 32'(req.rate);
        if (req.start) begin
          state_nxt = SN_MOD_A;
        end
      end
      SN_MOD_A: begin
        v_nxt     = prod_r[22:0];
        mul_a     = 32'(prod_r[22:0]);
        mul_b     = RECIP_8000;
        state_nxt = SN_MOD_B;
      end
      SN_MOD_B: begin
        p_nxt     = p_fix;
        state_nxt = SN_FOLD;
      end
      SN_FOLD: begin
        x_nxt     = x_f;
        neg_nxt   = neg_f;
        state_nxt = SN_TH_A;
      end
      SN_TH_A: begin
        mul_a     = 32'(x_r);
        mul_b     = THETA_INT;
        state_nxt = SN_TH_B;
      end
      SN_TH_B: begin
        theta_nxt = prod_r[30:0];
        mul_a     = 32'(x_r);
        mul_b     = THETA_FRAC;
        state_nxt = SN_TH_C;
      end
      SN_TH_C: begin
        mul_a     = 32'(prod_r[22:5]);
        mul_b     = RECIP_125;
        state_nxt = SN_TH_D;
      end
      SN_TH_D: begin
        theta_nxt = theta_r + 31'(prod_r[35:25]);
        state_nxt = SN_SQ_A;
      end
      SN_SQ_A: begin
        mul_a     = 32'(theta_r);
        mul_b     = 32'(theta_r);
        state_nxt = SN_SQ_B;
      end
      SN_SQ_B: begin
        t2_nxt    = prod_r[61:30];
        dv_nxt    = prod_r[61:30];
        k_nxt     = '0;
        state_nxt = SN_DIV_A;
      end
      SN_DIV_A: begin
        mul_a     = dv_r;
        mul_b     = div_recip(k_r);
        state_nxt = SN_DIV_B;
      end
      SN_DIV_B: begin
        a_nxt = 31'(ONE) - quo;
        if (k_r == LAST_TERM) begin
          state_nxt = SN_FIN_A;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = SN_MT_A;
        end
      end
      SN_MT_A: begin
        mul_a     = t2_r;
        mul_b     = 32'(a_r);
        state_nxt = SN_MT_B;
      end
      SN_MT_B: begin
        dv_nxt    = prod_r[61:30];
        state_nxt = SN_DIV_A;
      end
      SN_FIN_A: begin
        mul_a     = 32'(theta_r);
        mul_b     = 32'(a_r);
        state_nxt = SN_FIN_B;
      end
      SN_FIN_B: begin
        bias_nxt  = neg_r ? (ONE - s_cl) : (ONE + s_cl);
        state_nxt = SN_FIN_C;
      end
      SN_FIN_C: begin
        mul_a     = bias_r;
        mul_b     = SCALE;
        state_nxt = SN_FIN_D;
      end
      SN_FIN_D: begin
        res_nxt.done   = 1'b1;
        res_nxt.sample = (smp > SAMPLE_MAX) ? SAMPLE_MAX[CMP_W-1:0] : smp[CMP_W-1:0];
        state_nxt      = SN_IDLE;
      end
      default: state_nxt = SN_IDLE;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SN_IDLE;
      res_r.done <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      res_r.done <= res_nxt.done;
    end
    res_r.sample <= res_nxt.sample;
    prod_r  <= prod_nxt;
    v_r     <= v_nxt;
    p_r     <= p_nxt;
    x_r     <= x_nxt;
    neg_r   <= neg_nxt;
    theta_r <= theta_nxt;
    t2_r    <= t2_nxt;
    dv_r    <= dv_nxt;
    a_r     <= a_nxt;
    bias_r  <= bias_nxt;
    k_r     <= k_nxt;
  end

  assign res = res_r;

endmodule

// ----- rtl/core/button_controlled_waveform_pwm_core.sv -----
// Key-driven waveform generator feeding a PWM compare register.
// in_ch carries one transaction per tick: action 0 is a key scan with the two
// key states, action 1 is a PWM update. out_ch returns exactly one transaction
// per input: compare_write/compare_value (value is zero when nothing is
// written), the waveform code and the select-mode flag after the tick.
// cfg_we/cfg_wdata load the PWM period (reset 999) at which the sine sample
// index wraps; write it only while the block is idle.
// Per-waveform settings live in a three-word memory, read on accept and
// written back in the following cycle. Key ticks and DC/sawtooth updates pass
// from accept through the execute and done states to the output register; a
// sine update also waits for the sine unit, which runs modulo, angle scaling,
// squaring and five series terms through one shared 32x32 multiplier.
// One item is worked on at a time; in_ch.ready is high while the core is idle,
// including while a finished result still waits in the output register, so a
// new transaction is taken only once the last result has been loaded there.
// When out_ch stalls, the next result is held until the register frees up.
// Reset is synchronous: select mode on, DC waveform, all memory words read as
// their reset values until written, key window empty, output empty.
module button_controlled_waveform_pwm_core #(
  parameter int WINDOW_LEN = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bcwp_pkg::PERIOD_W-1:0] cfg_wdata,
  bcwp_in_if.sink                       in_ch,
  bcwp_out_if.source                    out_ch
);
  import bcwp_pkg::*;

  localparam int              RUN_W          = $clog2(WINDOW_LEN + 1);
  localparam logic [RUN_W-1:0] RUN_FULL      = RUN_W'(WINDOW_LEN);
  localparam logic            LAST_WANT_KEY2 = ((WINDOW_LEN % 2) == 0);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SINE, S_DONE} state_t;

  function automatic logic [MODE_W-1:0] next_kind(input logic [MODE_W-1:0] kind);
    logic [MODE_W-1:0] nk;
    nk = WAVE_SINE;
    case (kind)
      WAVE_DC:   nk = WAVE_SINE;
      WAVE_SINE: nk = WAVE_SAW;
      WAVE_SAW:  nk = WAVE_DC;
      default:   nk = WAVE_SINE;
    endcase
    return nk;
  endfunction

  state_t            state_r, state_nxt;
  logic              sel_r, sel_nxt;
  logic [MODE_W-1:0] kind_r, kind_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              last_key2_r, last_key2_nxt;
  logic [WAVE_CNT-1:0] valid_r, valid_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic              act_r, act_nxt;
  logic              k1_r, k1_nxt;
  logic              k2_r, k2_nxt;
  logic              res_write_r, res_write_nxt;
  logic [CMP_W-1:0]  res_value_r, res_value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_write_r, out_write_nxt;
  logic [CMP_W-1:0]  out_value_r, out_value_nxt;
  logic [MODE_W-1:0] out_mode_r, out_mode_nxt;
  logic              out_sel_r, out_sel_nxt;

  logic              ram_we, ram_re;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [ENT_W-1:0]  ent;
  logic              kind_ok;
  sine_req_t         sine_req;
  sine_res_t         sine_res;

  // per-waveform state memory
  bcwp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(WAVE_CNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(kind_r[ENT_AW-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(kind_r[ENT_AW-1:0]),
    .rdata(ram_rdata)
  );

  bcwp_sine u_sine (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sine_req),
    .res  (sine_res)
  );

  // never-written words read as their reset values
  assign kind_ok = (kind_r != WAVE_NONE);
  assign ent     = (kind_ok && valid_r[kind_r[ENT_AW-1:0]]) ? ram_rdata
                                                            : entry_reset(kind_r);

  // main control and read-modify-write of the state word
  always_comb begin
    logic [LEVEL_W-1:0] dc_t;
    logic [RATE_W-1:0]  rate_t;
    logic [LEVEL_W-1:0] lvl_t;
    logic [IDX_W:0]     idx_inc;
    logic [IDX_W-1:0]   idx_t;
    logic [RUN_W-1:0]   run_inc;
    logic               key2_pushed;

    dc_t        = ent[LEVEL_W-1:0];
    rate_t      = ent[RATE_W-1:0];
    lvl_t       = ent[RATE_W+LEVEL_W-1:RATE_W];
    idx_inc     = {1'b0, ent[ENT_W-1:RATE_W]} + 1'b1;
    idx_t       = (idx_inc >= {1'b0, period_r}) ? '0 : idx_inc[IDX_W-1:0];
    key2_pushed = !k1_r;
    if ((run_r != '0) && (last_key2_r != key2_pushed)) begin
      run_inc = (run_r == RUN_FULL) ? RUN_FULL : run_r + 1'b1;
    end else begin
      run_inc = RUN_W'(1);
    end

    state_nxt     = state_r;
    sel_nxt       = sel_r;
    kind_nxt      = kind_r;
    run_nxt       = run_r;
    last_key2_nxt = last_key2_r;
    valid_nxt     = valid_r;
    period_nxt    = cfg_we ? cfg_wdata : period_r;
    act_nxt       = act_r;
    k1_nxt        = k1_r;
    k2_nxt        = k2_r;
    res_write_nxt = res_write_r;
    res_value_nxt = res_value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_write_nxt = out_write_r;
    out_value_nxt = out_value_r;
    out_mode_nxt  = out_mode_r;
    out_sel_nxt   = out_sel_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = ent;
    sine_req.start = 1'b0;
    sine_req.idx   = ent[ENT_W-1:RATE_W];
    sine_req.rate  = ent[RATE_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = in_ch.action;
          k1_nxt    = in_ch.key1_down;
          k2_nxt    = in_ch.key2_down;
          ram_re    = kind_ok;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_write_nxt = 1'b0;
        res_value_nxt = '0;
        state_nxt     = S_DONE;
        if (!act_r) begin
          if (!sel_r) begin
            // key window: alternating run ending in the expected key
            if (k1_r || k2_r) begin
              last_key2_nxt = key2_pushed;
              if ((run_inc == RUN_FULL) && (key2_pushed == LAST_WANT_KEY2)) begin
                run_nxt = '0;
                sel_nxt = 1'b1;
              end else begin
                run_nxt = run_inc;
              end
            end
            case (kind_r)
              WAVE_DC: begin
                if (k1_r && (dc_t > DC_STEP)) dc_t = dc_t - DC_STEP;
                if (k2_r && (dc_t < DC_MAX)) dc_t = dc_t + DC_STEP;
                ram_we    = 1'b1;
                ram_wdata = ENT_W'(dc_t);
                if (k1_r || k2_r) begin
                  res_write_nxt = 1'b1;
                  res_value_nxt = dc_t;
                end
              end
              WAVE_SINE: begin
                if (k1_r && (rate_t > SINE_RATE_MIN)) rate_t = rate_t - 1'b1;
                if (k2_r && (rate_t < SINE_RATE_MAX)) rate_t = rate_t + 1'b1;
                ram_we    = 1'b1;
                ram_wdata = {ent[ENT_W-1:RATE_W], rate_t};
              end
              WAVE_SAW: begin
                if (k1_r && (rate_t > RAMP_RATE_MIN)) rate_t = rate_t - RAMP_RATE_STEP;
                if (k2_r && (rate_t < RAMP_RATE_MAX)) rate_t = rate_t + RAMP_RATE_STEP;
                ram_we    = 1'b1;
                ram_wdata = {ent[ENT_W-1:RATE_W], rate_t};
              end
              default: ;
            endcase
          end else begin
            if (k2_r) kind_nxt = next_kind(kind_r);
            if (k1_r) sel_nxt = 1'b0;
          end
        end else begin
          case (kind_r)
            WAVE_SINE: begin
              sine_req.start = 1'b1;
              ram_we         = 1'b1;
              ram_wdata      = {idx_t, rate_t};
              state_nxt      = S_SINE;
            end
            WAVE_SAW: begin
              lvl_t         = lvl_t + LEVEL_W'(rate_t >> 3);
              res_write_nxt = 1'b1;
              res_value_nxt = lvl_t;
              ram_we        = 1'b1;
              ram_wdata     = {ent[ENT_W-1:RATE_W+LEVEL_W],
                               (lvl_t > RAMP_TOP) ? {LEVEL_W{1'b0}} : lvl_t,
                               rate_t};
            end
            default: ;
          endcase
        end
        if (ram_we) valid_nxt[kind_r[ENT_AW-1:0]] = 1'b1;
      end
      S_SINE: begin
        if (sine_res.done) begin
          res_write_nxt = 1'b1;
          res_value_nxt = sine_res.sample;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        // load the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_write_nxt = res_write_r;
          out_value_nxt = res_value_r;
          out_mode_nxt  = kind_r;
          out_sel_nxt   = sel_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b1;
      kind_r      <= WAVE_DC;
      run_r       <= '0;
      last_key2_r <= 1'b0;
      valid_r     <= '0;
      period_r    <= PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      kind_r      <= kind_nxt;
      run_r       <= run_nxt;
      last_key2_r <= last_key2_nxt;
      valid_r     <= valid_nxt;
      period_r    <= period_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r       <= act_nxt;
    k1_r        <= k1_nxt;
    k2_r        <= k2_nxt;
    res_write_r <= res_write_nxt;
    res_value_r <= res_value_nxt;
    out_write_r <= out_write_nxt;
    out_value_r <= out_value_nxt;
    out_mode_r  <= out_mode_nxt;
    out_sel_r   <= out_sel_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.compare_write = out_write_r;
  assign out_ch.compare_value = out_value_r;
  assign out_ch.wave_mode     = out_mode_r;
  assign out_ch.in_select     = out_sel_r;

`ifndef ASSERT_OFF
  a_sine_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
    sine_req.start |-> (kind_r == WAVE_SINE) && act_r)
    else $error("sine unit started outside a sine update");
  a_sine_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sine_res.done |-> (state_r == S_SINE))
    else $error("sine result arrived while not waiting for it");
  a_ram_we_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> kind_ok && (state_r == S_EXEC))
    else $error("state memory written outside the execute step");
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (run_r <= RUN_FULL) && (state_r != S_EXEC))
    else $error("key window run out of range or execute step repeated");
`endif

endmodule

// ----- test/button_controlled_waveform_pwm_core_tb.sv -----
`timescale 1ns / 100ps

module button_controlled_waveform_pwm_core_tb;
  import bcwp_pkg::*;

  localparam int WINDOW_LEN    = 4;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int PHASES        = 6;
  localparam int DIRECTED_CNT  = 25;

  // tick kinds and key window codes
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_PWM  = 1'b1;
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_ONE  = 2'd1;
  localparam logic [1:0] KEY_TWO  = 2'd2;

  // whether a directed row carries its own expected result
  localparam logic FROM_MODEL = 1'b0;
  localparam logic FROM_TABLE = 1'b1;

  localparam logic [63:0] Q30_UNIT      = 64'd1073741824;
  localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;

  typedef struct packed {
    logic              wr;
    logic [CMP_W-1:0]  value;
    logic [MODE_W-1:0] wave;
    logic              sel;
  } pwm_result_t;

  typedef struct packed {
    logic        act;
    logic        k1;
    logic        k2;
    logic        known;
    pwm_result_t res;
  } stim_row_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BEAT} sink_style_t;

  // directed stimulus: mode walk, key window return, clamps at zero, first samples
  localparam stim_row_t DIRECTED [DIRECTED_CNT] = '{
    {ACT_PWM,  1'b1, 1'b1, FROM_TABLE, 1'b0, 10'd0,   WAVE_DC,   1'b1},
    {ACT_SCAN, 1'b0, 1'b0, FROM_TABLE, 1'b0, 10'd0,   WAVE_DC,   1'b1},
    {ACT_SCAN, 1'b0, 1'b1, FROM_TABLE, 1'b0, 10'd0,   WAVE_SINE, 1'b1},
    {ACT_SCAN, 1'b0, 1'b1, FROM_TABLE, 1'b0, 10'd0,   WAVE_SAW,  1'b1},
    {ACT_SCAN, 1'b0, 1'b1, FROM_TABLE, 1'b0, 10'd0,   WAVE_DC,   1'b1},
    {ACT_SCAN, 1'b1, 1'b0, FROM_TABLE, 1'b0, 10'd0,   WAVE_DC,   1'b0},
    {ACT_SCAN, 1'b1, 1'b0, FROM_TABLE, 1'b1, 10'd0,   WAVE_DC,   1'b0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_TABLE, 1'b1, 10'd10,  WAVE_DC,   1'b0},
    {ACT_SCAN, 1'b1, 1'b0, FROM_TABLE, 1'b1, 10'd10,  WAVE_DC,   1'b0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_TABLE, 1'b1, 10'd20,  WAVE_DC,   1'b1},
    {ACT_SCAN, 1'b1, 1'b1, FROM_TABLE, 1'b0, 10'd0,   WAVE_SINE, 1'b0},
    {ACT_PWM,  1'b0, 1'b0, FROM_TABLE, 1'b1, 10'd499, WAVE_SINE, 1'b0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_MODEL, 14'd0},
    {ACT_PWM,  1'b0, 1'b0, FROM_MODEL, 14'd0},
    {ACT_SCAN, 1'b1, 1'b1, FROM_MODEL, 14'd0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_MODEL, 14'd0},
    {ACT_SCAN, 1'b1, 1'b0, FROM_MODEL, 14'd0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_MODEL, 14'd0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_TABLE, 1'b0, 10'd0,   WAVE_SAW,  1'b1},
    {ACT_SCAN, 1'b1, 1'b0, FROM_TABLE, 1'b0, 10'd0,   WAVE_SAW,  1'b0},
    {ACT_PWM,  1'b0, 1'b0, FROM_TABLE, 1'b1, 10'd1,   WAVE_SAW,  1'b0},
    {ACT_SCAN, 1'b0, 1'b1, FROM_MODEL, 14'd0},
    {ACT_PWM,  1'b0, 1'b0, FROM_MODEL, 14'd0},
    {ACT_SCAN, 1'b1, 1'b0, FROM_MODEL, 14'd0},
    {ACT_PWM,  1'b1, 1'b1, FROM_MODEL, 14'd0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  bcwp_in_if  in_ch ();
  bcwp_out_if out_ch ();

  button_controlled_waveform_pwm_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // generator state as the testbench sees it
  logic                sel_mode;
  logic [MODE_W-1:0]   wave;
  logic [LEVEL_W-1:0]  dc_lvl;
  logic [RATE_W-1:0]   sine_step;
  logic [RATE_W-1:0]   ramp_step;
  logic [LEVEL_W-1:0]  ramp_lvl;
  logic [IDX_W-1:0]    sample_idx;
  logic [PERIOD_W-1:0] period;
  logic [1:0]          key_hist [WINDOW_LEN];

  pwm_result_t awaited_results [$];

  int unsigned sent_ticks = 0;
  int unsigned active_ticks = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned sine_samples = 0;
  int unsigned ramp_samples = 0;
  int unsigned duty_writes = 0;
  int unsigned window_hits = 0;
  int unsigned periods_loaded = 0;
  int unsigned burst_left = 0;
  int unsigned sink_left = 0;
  sink_style_t sink_style = SINK_OPEN;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic reset_generator();
    sel_mode   = 1'b1;
    wave       = WAVE_DC;
    dc_lvl     = '0;
    sine_step  = SINE_RATE_MIN;
    ramp_step  = RAMP_RATE_MIN;
    ramp_lvl   = '0;
    sample_idx = '0;
    period     = PERIOD_RESET;
    for (int i = 0; i < WINDOW_LEN; i++) key_hist[i] = KEY_NONE;
  endtask

  // q30 sine of phase/8000 of a turn, scaled to the 0..998 compare range
  function automatic logic [CMP_W-1:0] sine_level(input int unsigned phase);
    int unsigned quadrant;
    int unsigned offset;
    logic [63:0] theta, t2, acc, mag, biased, level;
    quadrant = phase / 2000;
    offset   = phase % 2000;
    theta    = (quadrant % 2 == 1) ? 2000 - offset : offset;
    theta    = theta * HALF_TURN_Q30 / 64'd4000;
    t2       = (theta * theta) >> 30;
    acc      = Q30_UNIT - t2 / 110;
    acc      = Q30_UNIT - ((t2 * acc) >> 30) / 72;
    acc      = Q30_UNIT - ((t2 * acc) >> 30) / 42;
    acc      = Q30_UNIT - ((t2 * acc) >> 30) / 20;
    acc      = Q30_UNIT - ((t2 * acc) >> 30) / 6;
    mag      = (theta * acc) >> 30;
    if (mag > Q30_UNIT) mag = Q30_UNIT;
    biased = (quadrant >= 2) ? Q30_UNIT - mag : Q30_UNIT + mag;
    level  = (biased * 499) >> 30;
    if (level > 998) level = 998;
    return level[CMP_W-1:0];
  endfunction

  // shift a press into the window; true when it reads key1,key2,key1,key2
  function automatic logic push_key(input logic [1:0] code);
    logic hit;
    int   i;
    for (i = 0; i < WINDOW_LEN - 1; i++) key_hist[i] = key_hist[i + 1];
    key_hist[WINDOW_LEN - 1] = code;
    hit = 1'b1;
    for (i = 0; i < WINDOW_LEN; i++)
      if (key_hist[i] != ((i % 2 == 1) ? KEY_TWO : KEY_ONE)) hit = 1'b0;
    if (hit)
      for (i = 0; i < WINDOW_LEN; i++) key_hist[i] = KEY_NONE;
    return hit;
  endfunction

  // advance the generator by one tick and return the transaction it gives
  function automatic pwm_result_t tick_outcome(input logic act, input logic k1, input logic k2);
    pwm_result_t res;
    logic [IDX_W:0] next_idx;
    int unsigned    phase;
    res = '0;
    if (act == ACT_SCAN) begin
      if (!sel_mode) begin
        if ((k1 || k2) && push_key(k1 ? KEY_ONE : KEY_TWO)) begin
          sel_mode = 1'b1;
          window_hits++;
        end
        if (k1) begin
          case (wave)
            WAVE_DC: begin
              if (dc_lvl > DC_STEP) dc_lvl = dc_lvl - DC_STEP;
              res.wr = 1'b1;
            end
            WAVE_SINE: if (sine_step > SINE_RATE_MIN) sine_step = sine_step - 7'd1;
            WAVE_SAW:  if (ramp_step > RAMP_RATE_MIN) ramp_step = ramp_step - RAMP_RATE_STEP;
            default: ;
          endcase
        end
        if (k2) begin
          case (wave)
            WAVE_DC: begin
              if (dc_lvl < DC_MAX) dc_lvl = dc_lvl + DC_STEP;
              res.wr = 1'b1;
            end
            WAVE_SINE: if (sine_step < SINE_RATE_MAX) sine_step = sine_step + 7'd1;
            WAVE_SAW:  if (ramp_step < RAMP_RATE_MAX) ramp_step = ramp_step + RAMP_RATE_STEP;
            default: ;
          endcase
        end
        if (res.wr) begin
          res.value = dc_lvl;
          duty_writes++;
        end
      end else begin
        if (k2) wave = MODE_W'((wave + 3'd1) % 3'd3);
        if (k1) sel_mode = 1'b0;
      end
    end else if (wave == WAVE_SINE) begin
      phase      = (sample_idx * sine_step) % 8000;
      res.wr     = 1'b1;
      res.value  = sine_level(phase);
      next_idx   = {1'b0, sample_idx} + 1'b1;
      sample_idx = (next_idx >= {1'b0, period}) ? '0 : next_idx[IDX_W-1:0];
      sine_samples++;
    end else if (wave == WAVE_SAW) begin
      ramp_lvl  = LEVEL_W'(ramp_lvl + ramp_step / 8);
      res.wr    = 1'b1;
      res.value = ramp_lvl;
      if (ramp_lvl > RAMP_TOP) ramp_lvl = '0;
      ramp_samples++;
    end
    res.wave = wave;
    res.sel  = sel_mode;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input pwm_result_t want,
                                 input pwm_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected wr=%0b value=%0d wave=%0d sel=%0b, got wr=%0b value=%0d wave=%0d sel=%0b",
               $realtime, what, want.wr, want.value, want.wave, want.sel,
               got.wr, got.value, got.wave, got.sel);
  endtask

  // sender gap: drop valid and scramble the payload
  task automatic idle_for(input int unsigned cycles);
    in_ch.valid     <= 1'b0;
    in_ch.action    <= 1'($urandom_range(0, 1));
    in_ch.key1_down <= 1'($urandom_range(0, 1));
    in_ch.key2_down <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  // present one tick, wait until it is accepted, record the expected result
  task automatic send_tick(input logic act, input logic k1, input logic k2,
                           input logic known, input pwm_result_t table_res);
    pwm_result_t res;
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.key1_down <= k1;
    in_ch.key2_down <= k2;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (!((act == ACT_PWM && wave == WAVE_DC) || (act == ACT_SCAN && !k1 && !k2)))
      active_ticks++;
    sent_ticks++;
    res = tick_outcome(act, k1, k2);
    awaited_results.push_back(known ? table_res : res);
    // bursts of random length, most of them followed by a gap
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 25));
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_rand(input logic act);
    send_tick(act, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), FROM_MODEL, '0);
  endtask

  // hold the sender until every expected result is back, then settle
  task automatic drain_results(input int settle);
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (awaited_results.size() != 0 && waited < DRAIN_LIMIT);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_period(input logic [PERIOD_W-1:0] value);
    drain_results(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= PERIOD_W'($urandom);
    period = value;
    periods_loaded++;
  endtask

  // mostly well-formed mode walks and key runs, some noise and broken sequences
  task automatic random_phase(input int unsigned quota);
    int unsigned start;
    int unsigned len;
    int unsigned broken;
    int          i;
    logic        k1, k2;
    start = sent_ticks;
    while (sent_ticks - start < quota) begin
      case ($urandom_range(0, 9))
        0: begin
          if ($urandom_range(0, 5) == 0) drain_results(0);
          len = $urandom_range(1, 6);
          repeat (len) send_rand(1'($urandom_range(0, 1)));
        end
        1, 2: begin
          if (sel_mode) begin
            len = $urandom_range(0, 3);
            repeat (len) send_tick(ACT_SCAN, 1'b0, 1'b1, FROM_MODEL, '0);
            send_tick(ACT_SCAN, 1'b1, $urandom_range(0, 3) == 0, FROM_MODEL, '0);
          end else begin
            broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
            for (i = 0; i < 4; i++) begin
              if (i == broken) send_rand(ACT_SCAN);
              else send_tick(ACT_SCAN, i % 2 == 0, i % 2 == 1, FROM_MODEL, '0);
            end
          end
        end
        3, 4, 5: begin
          if (sel_mode) send_tick(ACT_SCAN, 1'b1, 1'b0, FROM_MODEL, '0);
          case ($urandom_range(0, 4))
            0, 1:    {k1, k2} = 2'b10;
            2, 3:    {k1, k2} = 2'b01;
            default: {k1, k2} = 2'b11;
          endcase
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 110) : $urandom_range(1, 10);
          repeat (len) begin
            if ($urandom_range(0, 5) == 0) send_rand(ACT_PWM);
            send_tick(ACT_SCAN, k1, k2, FROM_MODEL, '0);
          end
        end
        default: begin
          len = (wave == WAVE_DC) ? $urandom_range(1, 3) : $urandom_range(1, 40);
          repeat (len) begin
            if ($urandom_range(0, 7) == 0) send_tick(ACT_SCAN, 1'b0, 1'b0, FROM_MODEL, '0);
            else send_rand(ACT_PWM);
          end
        end
      endcase
    end
  endtask

  // receiver stalls: styles switch after random stretches
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_style <= sink_style_t'($urandom_range(0, 3));
      sink_left  <= $urandom_range(16, 160);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_style)
      SINK_OPEN:   out_ch.ready <= 1'b1;
      SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default:     out_ch.ready <= sink_left[2];
    endcase
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    pwm_result_t got;
    pwm_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.compare_write, out_ch.compare_value, out_ch.wave_mode, out_ch.in_select};
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.wr !== want.wr || got.value !== want.value ||
            got.wave !== want.wave || got.sel !== want.sel)
          report_mismatch("result", want, got);
      end
    end
  end

  initial begin
    #25000000;
    $display("button_controlled_waveform_pwm_core: mismatch");
    $finish;
  end

  initial begin
    int r;
    int ph;
    reset_generator();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= 1'b0;
    in_ch.key1_down <= 1'b0;
    in_ch.key2_down <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset period
    for (r = 0; r < DIRECTED_CNT; r++)
      send_tick(DIRECTED[r].act, DIRECTED[r].k1, DIRECTED[r].k2,
                DIRECTED[r].known, DIRECTED[r].res);

    // random phases; after each but the last a new period is loaded
    for (ph = 0; ph < PHASES; ph++) begin
      random_phase(RANDOM_ITEMS / PHASES);
      case (ph)
        0:       load_period(16'd1);
        1:       load_period(16'd65535);
        2:       load_period(16'd7);
        3:       load_period(PERIOD_W'($urandom_range(2, 400)));
        4:       load_period(16'd999);
        default: ;
      endcase
    end

    drain_results(SETTLE_CYCLES);
    if (awaited_results.size() != 0) begin
      $display("%0d expected results never arrived", awaited_results.size());
      mismatches += awaited_results.size();
    end

    $display("%0d ticks sent (%0d with effect), %0d results checked, %0d period loads",
             sent_ticks, active_ticks, results_seen, periods_loaded);
    $display("%0d sine samples, %0d ramp samples, %0d duty writes, %0d window returns",
             sine_samples, ramp_samples, duty_writes, window_hits);
    if (mismatches == 0) begin
      $display("button_controlled_waveform_pwm_core: match");
    end else begin
      $display("button_controlled_waveform_pwm_core: mismatch");
    end
    $finish;
  end

endmodule
